// ===== src/bffla_pkg.sv =====
package bffla_pkg;

    localparam int HEAP_BYTES      = 65536;
    localparam int ALIGN_BYTES     = 8;
    localparam int HEADER_BYTES    = 24;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int FREE_ENTRIES    = 16;

    localparam int ADDR_W   = 16;
    localparam int BYTES_W  = 17;
    localparam int AGE_W    = $clog2(FREE_ENTRIES);
    localparam int SLOT_W   = $clog2(FREE_ENTRIES);
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
    localparam int STORE_DEPTH = (HEAP_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
    localparam int STORE_AW = $clog2(STORE_DEPTH);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NULLREL = 3'd4;

    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // data travelling down the cell row during the search
    typedef struct packed {
        logic               found;
        logic [BYTES_W-1:0] bytes;
        logic [AGE_W-1:0]   age;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  start;
        logic               has_free;
        logic [SLOT_W-1:0]  free_slot;
    } chain_t;

    // command broadcast to all cells
    typedef struct packed {
        logic [1:0]         op;
        logic [SLOT_W-1:0]  slot;
        logic [AGE_W-1:0]   age;
        logic [ADDR_W-1:0]  start;
        logic [BYTES_W-1:0] bytes;
    } cell_cmd_t;

endpackage

// ===== src/bffla_ram.sv =====
module bffla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bffla_cell.sv =====
module bffla_cell import bffla_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SLOT_W-1:0]   my_slot,
    input  logic [BYTES_W-1:0]  need,
    input  logic                chain_clr,
    input  chain_t              chain_in,
    output chain_t              chain_out,
    input  cell_cmd_t           cmd
);

    logic               valid_reg;
    logic [ADDR_W-1:0]  start_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [AGE_W-1:0]   age_reg;
    chain_t             pass_reg;
    chain_t             pass_next;
    logic               better;

    always_comb
    begin
        pass_next = chain_clr ? '0 : chain_in;
        better = valid_reg && bytes_reg != '0 && bytes_reg >= need &&
                 (!pass_next.found || bytes_reg < pass_next.bytes ||
                  (bytes_reg == pass_next.bytes && age_reg < pass_next.age));
        if (better)
        begin
            pass_next.found = 1'b1;
            pass_next.bytes = bytes_reg;
            pass_next.age   = age_reg;
            pass_next.slot  = my_slot;
            pass_next.start = start_reg;
        end
        if (!valid_reg && !pass_next.has_free)
        begin
            pass_next.has_free  = 1'b1;
            pass_next.free_slot = my_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pass_reg  <= '0;
        end
        else
        begin
            pass_reg <= pass_next;
            case (cmd.op)
                OP_INSERT:
                begin
                    if (cmd.slot == my_slot)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (cmd.slot == my_slot)
                    begin
                        valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_INSERT:
            begin
                if (cmd.slot == my_slot)
                begin
                    start_reg <= cmd.start;
                    bytes_reg <= cmd.bytes;
                    age_reg   <= '0;
                end
                else if (valid_reg)
                begin
                    age_reg <= age_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (valid_reg && age_reg > cmd.age)
                begin
                    age_reg <= age_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign chain_out = pass_reg;

endmodule

// ===== src/best_fit_free_list_allocator.sv =====
// Best-fit heap allocator with a free table of FREE_ENTRIES slots.
// s_axis carries one request per beat; m_axis returns one result per beat.
// Config: cfg_we with cfg_data sets heap_limit, write only while idle.
// The free table is a row of cells; the search result ripples one cell
// per cycle through the whole row during the scan.
// An allocate passes through the scan and the decision, plus a split step
// when the block is split; a release of a real block passes through the
// scan, a wait for the registered RAM read and its use; a zero-size
// allocate, a null release and a release below the header go straight to the result.
// One request is in work at a time; s_axis_tready is high only while no
// request is open, so the next request is taken no earlier than the cycle
// after the result beat is delivered.
// Block sizes sit in a STORE_DEPTH-entry RAM with a registered read.
// Reset empties the free table, clears the break pointer and sets
// heap_limit to 65536. The RAM is not cleared.
// When m_axis_tready is low the result beat holds and no new request is
// taken until it is delivered.
module best_fit_free_list_allocator import bffla_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: [15:0] request_size, [31:16] release_address
    input  logic [31:0]        s_axis_tdata,
    // tuser: [0] kind
    input  logic               s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // tdata: [15:0] payload_address, [18:16] status, rest zero
    output logic [23:0]        m_axis_tdata,
    input  logic               cfg_we,
    input  logic [BYTES_W-1:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_RDUSE  = 3'd4;
    localparam logic [2:0] S_SPLIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [BYTES_W-1:0] limit_reg;
    logic [BYTES_W-1:0] brk_reg, brk_next;
    logic               kind_reg, kind_next;
    logic [BYTES_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [BYTES_W-1:0] rest_reg, rest_next;
    logic [ADDR_W-1:0]  rstart_reg, rstart_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [2:0]         out_stat_reg, out_stat_next;
    logic               out_valid_reg, out_valid_next;
    chain_t             res_reg, res_next;

    chain_t             chain [FREE_ENTRIES+1];
    cell_cmd_t          cmd;
    logic               chain_clr;

    logic               ram_we;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [BYTES_W-1:0] ram_wdata, ram_rdata;

    logic [BYTES_W-1:0] size_up, need_calc, lim;
    logic [BYTES_W-1:0] rel_start;

    assign chain[0] = '0;

    for (genvar g = 0; g < FREE_ENTRIES; g++)
    begin : g_cell
        bffla_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .my_slot  (SLOT_W'(g)),
            .need     (need_reg),
            .chain_clr(chain_clr),
            .chain_in (chain[g]),
            .chain_out(chain[g+1]),
            .cmd      (cmd)
        );
    end

    bffla_ram #(.WIDTH(BYTES_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        size_up = ((BYTES_W'(s_axis_tdata[15:0]) + BYTES_W'(ALIGN_BYTES - 1))
                   >> ALIGN_SH) << ALIGN_SH;
        need_calc = ((size_up + BYTES_W'(HEADER_BYTES + ALIGN_BYTES - 1))
                     >> ALIGN_SH) << ALIGN_SH;
        if (need_calc < BYTES_W'(MIN_BLOCK_BYTES))
        begin
            need_calc = BYTES_W'(MIN_BLOCK_BYTES);
        end
        lim = (limit_reg > BYTES_W'(HEAP_BYTES)) ? BYTES_W'(HEAP_BYTES) : limit_reg;
        rel_start = BYTES_W'(addr_reg) - BYTES_W'(HEADER_BYTES);
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        brk_next       = brk_reg;
        kind_next      = kind_reg;
        need_next      = need_reg;
        addr_next      = addr_reg;
        rest_next      = rest_reg;
        rstart_next    = rstart_reg;
        out_addr_next  = out_addr_reg;
        out_stat_next  = out_stat_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        chain_clr      = 1'b0;
        cmd            = '0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = rel_start[ALIGN_SH +: STORE_AW];

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    kind_next = s_axis_tuser;
                    need_next = need_calc;
                    addr_next = s_axis_tdata[31:16];
                    out_addr_next = '0;
                    out_stat_next = ST_OK;
                    if (!s_axis_tuser && s_axis_tdata[15:0] == '0)
                    begin
                        out_stat_next = ST_ZERO;
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser && s_axis_tdata[31:16] == '0)
                    begin
                        out_stat_next = ST_NULLREL;
                        state_next = S_OUT;
                    end
                    else if (s_axis_tuser &&
                             s_axis_tdata[31:16] < ADDR_W'(HEADER_BYTES))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cnt_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                chain_clr = (cnt_reg == '0);
                if (cnt_reg == CNT_W'(FREE_ENTRIES))
                begin
                    res_next = chain[FREE_ENTRIES];
                    state_next = kind_reg ? S_RDWAIT : S_DECIDE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (res_reg.found)
                begin
                    cmd.op   = OP_REMOVE;
                    cmd.slot = res_reg.slot;
                    cmd.age  = res_reg.age;
                    out_addr_next = res_reg.start + ADDR_W'(HEADER_BYTES);
                    rest_next = res_reg.bytes - need_reg;
                    rstart_next = res_reg.start + need_reg[ADDR_W-1:0];
                    if (res_reg.bytes - need_reg >= BYTES_W'(MIN_BLOCK_BYTES))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = res_reg.start[ALIGN_SH +: STORE_AW];
                        ram_wdata = need_reg;
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (need_reg > lim || brk_reg > lim - need_reg)
                begin
                    out_stat_next = ST_NOMEM;
                    state_next = S_OUT;
                end
                else
                begin
                    brk_next = brk_reg + need_reg;
                    if (brk_reg < BYTES_W'(HEAP_BYTES))
                    begin
                        ram_we = 1'b1;
                    end
                    ram_waddr = brk_reg[ALIGN_SH +: STORE_AW];
                    ram_wdata = need_reg;
                    out_addr_next = brk_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    state_next = S_OUT;
                end
            end
            S_SPLIT:
            begin
                // after the remove the row's first free slot is the removed slot
                // or an earlier one; taking the lowest is what the table does
                cmd.op    = OP_INSERT;
                cmd.slot  = (res_reg.has_free && res_reg.free_slot < res_reg.slot)
                            ? res_reg.free_slot : res_reg.slot;
                cmd.start = rstart_reg;
                cmd.bytes = rest_reg;
                if ((BYTES_W'(rstart_reg) >> ALIGN_SH) < BYTES_W'(STORE_DEPTH))
                begin
                    ram_we = 1'b1;
                end
                ram_waddr = rstart_reg[ALIGN_SH +: STORE_AW];
                ram_wdata = rest_reg;
                state_next = S_OUT;
            end
            S_RDWAIT:
            begin
                state_next = S_RDUSE;
            end
            S_RDUSE:
            begin
                if (!res_reg.has_free)
                begin
                    out_stat_next = ST_FULL;
                end
                else
                begin
                    cmd.op    = OP_INSERT;
                    cmd.slot  = res_reg.free_slot;
                    cmd.start = rel_start[ADDR_W-1:0];
                    cmd.bytes = ram_rdata;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            brk_reg       <= '0;
            limit_reg     <= BYTES_W'(65536);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            brk_reg       <= brk_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        rest_reg     <= rest_next;
        rstart_reg   <= rstart_next;
        out_addr_reg <= out_addr_next;
        out_stat_reg <= out_stat_next;
        res_reg      <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_stat_reg, out_addr_reg};

endmodule

// ===== tb/best_fit_free_list_allocator_test.sv =====
module best_fit_free_list_allocator_test;
    import bffla_pkg::*;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct {
        logic        kind;
        logic [15:0] size;
        logic [15:0] addr;
    } req_t;

    typedef struct {
        logic [15:0] addr;
        logic [2:0]  status;
    } res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_we;
    logic [BYTES_W-1:0] cfg_data;

    best_fit_free_list_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    // allocator mirror
    int   free_start [FREE_ENTRIES];
    int   free_bytes [FREE_ENTRIES];
    int   free_age   [FREE_ENTRIES];
    bit   free_valid [FREE_ENTRIES];
    int   brk_bytes;
    int   limit_bytes;
    int   block_sizes [STORE_DEPTH];

    req_t        pending_reqs[$];
    res_t        expected_results[$];
    logic [15:0] live_addrs[$];
    req_t        cur_req;
    bit          calm;
    bit          hold_armed;
    int          hold_left;
    int          beats;
    int          errors;

    function automatic int align_up(int x);
        return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic bit table_add(int start, int bytes);
        int slot;
        slot = -1;
        for (int i = FREE_ENTRIES - 1; i >= 0; i--)
            if (!free_valid[i])
                slot = i;
        if (slot < 0)
            return 0;
        for (int i = 0; i < FREE_ENTRIES; i++)
            if (free_valid[i])
                free_age[i]++;
        free_start[slot] = start;
        free_bytes[slot] = bytes;
        free_age[slot]   = 0;
        free_valid[slot] = 1;
        return 1;
    endfunction

    function automatic res_t serve_request(req_t r);
        res_t o;
        int   need;
        int   best;
        int   start;
        int   rest;
        int   lim;
        o.addr   = '0;
        o.status = ST_OK;
        if (r.kind == KIND_ALLOC)
        begin
            if (r.size == 0)
                o.status = ST_ZERO;
            else
            begin
                need = align_up(HEADER_BYTES + align_up(int'(r.size)));
                if (need < MIN_BLOCK_BYTES)
                    need = MIN_BLOCK_BYTES;
                best = -1;
                for (int i = 0; i < FREE_ENTRIES; i++)
                begin
                    if (!free_valid[i] || free_bytes[i] < need)
                        continue;
                    if (best < 0 || free_bytes[i] < free_bytes[best] ||
                        (free_bytes[i] == free_bytes[best] && free_age[i] < free_age[best]))
                        best = i;
                end
                if (best >= 0)
                begin
                    start = free_start[best];
                    rest  = free_bytes[best] - need;
                    for (int i = 0; i < FREE_ENTRIES; i++)
                        if (free_valid[i] && free_age[i] > free_age[best])
                            free_age[i]--;
                    free_valid[best] = 0;
                    if (rest >= MIN_BLOCK_BYTES)
                    begin
                        block_sizes[start / ALIGN_BYTES] = need;
                        block_sizes[(start + need) / ALIGN_BYTES] = rest;
                        void'(table_add(start + need, rest));
                    end
                    o.addr = 16'(start + HEADER_BYTES);
                end
                else
                begin
                    lim = (limit_bytes > HEAP_BYTES) ? HEAP_BYTES : limit_bytes;
                    if (need > lim || brk_bytes > lim - need)
                        o.status = ST_NOMEM;
                    else
                    begin
                        start = brk_bytes;
                        brk_bytes += need;
                        block_sizes[start / ALIGN_BYTES] = need;
                        o.addr = 16'(start + HEADER_BYTES);
                    end
                end
            end
        end
        else if (r.addr == 0)
            o.status = ST_NULLREL;
        else if (r.addr >= HEADER_BYTES)
        begin
            start = int'(r.addr) - HEADER_BYTES;
            if (!table_add(start, block_sizes[start / ALIGN_BYTES]))
                o.status = ST_FULL;
        end
        return o;
    endfunction

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                res_t r;
                r = serve_request(cur_req);
                expected_results.push_back(r);
                if (cur_req.kind == KIND_ALLOC && r.status == ST_OK)
                    live_addrs.push_back(r.addr);
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 9))
                begin
                    cur_req = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_req.addr, cur_req.size};
                    s_axis_tuser  <= cur_req.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_armed <= 1'b1;
            hold_left  <= 0;
        end
        else if (hold_armed && beats >= 300)
        begin
            hold_armed <= 1'b0;
            hold_left  <= 400;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                beats++;
                if (expected_results.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected beat %h", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    res_t e;
                    e = expected_results.pop_front();
                    if (m_axis_tdata[15:0] !== e.addr || m_axis_tdata[18:16] !== e.status
                        || m_axis_tdata[23:19] !== 5'd0)
                    begin
                        if (errors < 10)
                            $display("mismatch beat %0d: expected addr %h status %0d, got %h",
                                     beats, e.addr, e.status, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= calm || $urandom_range(99) >= 9;
        end
    end

    task automatic queue_req(logic kind, logic [15:0] size, logic [15:0] addr);
        req_t r;
        r.kind = kind;
        r.size = size;
        r.addr = addr;
        while (pending_reqs.size() > 2)
            @(posedge clk);
        pending_reqs.push_back(r);
    endtask

    task automatic queue_release_live(bit unaligned);
        int          k;
        logic [15:0] a;
        k = $urandom_range(live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        if (unaligned)
            a = a + 16'($urandom_range(1, ALIGN_BYTES - 1));
        queue_req(KIND_FREE, 16'($urandom), a);
    endtask

    task automatic drain_and_set_limit(int value);
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= BYTES_W'(value);
        limit_bytes = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int roll;
        int n;
        n = 0;
        while (n < count)
        begin
            roll = $urandom_range(99);
            if (roll < 5)
            begin
                // burst of releases to fill the free table
                for (int j = 0; j < 20 && live_addrs.size() > 0; j++)
                begin
                    queue_release_live(0);
                    n++;
                end
            end
            else if (roll < 55)
            begin
                if ($urandom_range(19) == 0)
                    queue_req(KIND_ALLOC, 16'($urandom), 16'($urandom));
                else
                    queue_req(KIND_ALLOC, 16'($urandom_range(1, 300)), 16'($urandom));
                n++;
            end
            else if (roll < 90 && live_addrs.size() > 0)
            begin
                queue_release_live($urandom_range(9) == 0);
                n++;
            end
            else
            begin
                case ($urandom_range(2))
                    0: queue_req(KIND_FREE, 16'($urandom), 16'd0);
                    1: queue_req(KIND_FREE, 16'($urandom),
                                 16'($urandom_range(1, HEADER_BYTES - 1)));
                    default: queue_req(KIND_ALLOC, 16'd0, 16'($urandom));
                endcase
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        calm          = 0;
        beats         = 0;
        errors        = 0;
        brk_bytes     = 0;
        limit_bytes   = 65536;
        foreach (free_valid[i])
            free_valid[i] = 0;
        foreach (block_sizes[i])
            block_sizes[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_req(KIND_ALLOC, 16'd0, 16'hFFFF);
        queue_req(KIND_ALLOC, 16'd1, 16'h0000);
        queue_req(KIND_ALLOC, 16'd8, 16'h5555);
        queue_req(KIND_ALLOC, 16'd9, 16'hAAAA);
        queue_req(KIND_ALLOC, 16'd200, 16'h0000);
        queue_req(KIND_FREE, 16'hFFFF, 16'd0);
        queue_req(KIND_FREE, 16'h0000, 16'd1);
        queue_req(KIND_FREE, 16'h1234, 16'd23);
        queue_req(KIND_ALLOC, 16'hFFFF, 16'hFFFF);
        while (pending_reqs.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        // releases two random live blocks to try a split and a tie on equal sizes
        queue_release_live(0);
        queue_release_live(0);
        queue_req(KIND_ALLOC, 16'd1, 16'd0);
        queue_req(KIND_ALLOC, 16'd16, 16'd0);
        queue_req(KIND_ALLOC, 16'd40000, 16'd0);
        queue_req(KIND_ALLOC, 16'd30000, 16'd0);

        random_phase(300);
        // pause until every result is back
        drain_and_set_limit(4096);
        random_phase(250);
        drain_and_set_limit(0);
        random_phase(150);
        drain_and_set_limit(131071);
        calm = 1;
        random_phase(300);
        calm = 0;
        drain_and_set_limit(65536);
        random_phase(530);

        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
